>>> sv/fmma_pkg.sv
// Shared types and constants of the single-precision matrix multiply-accumulate unit.
// No dependencies; imported by every module of the block.
package fmma_pkg;

   // request type codes
   localparam logic [2:0] REQ_LOAD_A  = 3'd0;
   localparam logic [2:0] REQ_LOAD_B  = 3'd1;
   localparam logic [2:0] REQ_LOAD_C  = 3'd2;
   localparam logic [2:0] REQ_COMPUTE = 3'd3;
   localparam logic [2:0] REQ_READ_C  = 3'd4;

   // configuration register indexes
   localparam logic [1:0] REG_ROWS_A    = 2'd0;
   localparam logic [1:0] REG_INNER_DIM = 2'd1;
   localparam logic [1:0] REG_COLS_B    = 2'd2;

   localparam logic [6:0]  DIM_RESET = 7'd64;
   localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;

   typedef enum logic [3:0] {
      T_CLEAR,
      T_IDLE,
      T_READ,
      T_RDC,
      T_WAITC,
      T_RDAB,
      T_MAC,
      T_WAITF,
      T_WRC
   } top_state_type;

   typedef enum logic [3:0] {
      F_IDLE,
      F_MUL,
      F_LZC,
      F_NORM,
      F_DEN,
      F_RND,
      F_ALIGN,
      F_ADD
   } fpu_state_type;

   typedef struct packed {
      logic        valid;
      logic [31:0] a_bits;
      logic [31:0] b_bits;
      logic [31:0] acc_bits;
   } fpu_req_type;

   typedef struct packed {
      logic        valid;
      logic [31:0] sum_bits;
   } fpu_rsp_type;

endpackage

>>> sv/float_matrix_multiply_accumulate_unit.sv
// Top level of the single-precision matrix multiply-accumulate unit (C := C + A*B).
// Depends on fmma_pkg and fmma_fpu; holds the A, B and C memories and the sequencer.
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_ready  | req_type, req_row_index, req_col_index,
//           |           |                      | req_element_bits
//   rsp     | out       | rsp_valid/rsp_ready  | rsp_status, rsp_read_bits
//   csr     | in        | csr_valid/csr_ready  | csr_index, csr_wdata
//
// Loads, rejected items and computes with an empty row or column count answer in the cycle
// after they are taken; a read of C answers after the synchronous memory read and T_READ.
// A compute walks every entry of C: each term is an A/B memory read plus
// the multi-cycle multiply and add of fmma_fpu, which the accumulator chain serializes.
// After reset the C memory is zeroed one entry per cycle, all MAX_DIM*MAX_DIM entries (4096 at
// the default); no item is taken meanwhile, register writes are.
// A result waiting in the output register holds off the next item until it is taken.
module float_matrix_multiply_accumulate_unit #(
   parameter int MAX_DIM = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_type,
   input  logic [5:0]  req_row_index,
   input  logic [5:0]  req_col_index,
   input  logic [31:0] req_element_bits,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_status,
   output logic [31:0] rsp_read_bits,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [6:0]  csr_wdata
);
   import fmma_pkg::*;

   localparam int DEPTH = MAX_DIM * MAX_DIM;
   localparam int AW    = $clog2(DEPTH);

   top_state_type state_ff, state_in;

   // size registers, raw as written
   logic [6:0] rows_ff, inner_ff, cols_ff;
   // sizes clamped to MAX_DIM
   logic [6:0] dim_m, dim_n, dim_p;

   // loop counters: i row of C, j column of C, k term
   logic [6:0]    i_ff, j_ff, k_ff;
   logic [AW-1:0] clr_ff;
   logic [31:0]   acc_ff;

   logic        rsp_valid_ff, rsp_status_ff;
   logic [31:0] rsp_bits_ff;

   logic [31:0] a_mem [DEPTH];
   logic [31:0] b_mem [DEPTH];
   logic [31:0] c_mem [DEPTH];
   logic [31:0] a_rdata_ff, b_rdata_ff, c_rdata_ff;

   logic          req_fire, csr_fire;
   logic [6:0]    row7, col7;
   logic          rng_a, rng_b, rng_c;
   logic [AW-1:0] req_addr, a_raddr, b_raddr, c_raddr, c_waddr;
   logic          a_we, b_we, c_we;
   logic [31:0]   c_wdata;
   logic          rsp_load, rsp_status_in;
   logic [31:0]   rsp_bits_in;
   logic          last_j, last_i, last_k;

   fpu_req_type fpu_req;
   fpu_rsp_type fpu_rsp;

   function automatic logic [6:0] eff_dim(input logic [6:0] v);
      return ({25'd0, v} > 32'(MAX_DIM)) ? 7'(MAX_DIM) : v;
   endfunction

   // row-major address with a row pitch of MAX_DIM; request indexes reach it unchecked
   function automatic logic [AW-1:0] mem_addr(input logic [6:0] r, input logic [6:0] c);
      return AW'(r) * AW'(MAX_DIM) + AW'(c);
   endfunction

   fmma_fpu u_fpu (
      .clock   (clock),
      .reset   (reset),
      .fpu_req (fpu_req),
      .fpu_rsp (fpu_rsp)
   );

   assign dim_m = eff_dim(rows_ff);
   assign dim_n = eff_dim(inner_ff);
   assign dim_p = eff_dim(cols_ff);

   assign req_fire = req_valid && req_ready;
   assign csr_fire = csr_valid && csr_ready;
   assign csr_ready = 1'b1;

   assign row7     = {1'b0, req_row_index};
   assign col7     = {1'b0, req_col_index};
   assign rng_a    = (row7 < dim_m) && (col7 < dim_n);
   assign rng_b    = (row7 < dim_n) && (col7 < dim_p);
   assign rng_c    = (row7 < dim_m) && (col7 < dim_p);
   assign req_addr = mem_addr(row7, col7);

   assign last_j = (j_ff + 7'd1) == dim_p;
   assign last_i = (i_ff + 7'd1) == dim_m;
   assign last_k = (k_ff + 7'd1) == dim_n;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_read_bits = rsp_bits_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         T_CLEAR: if (clr_ff == AW'(DEPTH - 1)) state_in = T_IDLE;
         T_IDLE: begin
            if (req_fire) begin
               if (req_type == REQ_READ_C && rng_c) state_in = T_READ;
               else if (req_type == REQ_COMPUTE && dim_m != 7'd0 && dim_p != 7'd0)
                  state_in = T_RDC;
            end
         end
         T_READ:  state_in = T_IDLE;
         T_RDC:   state_in = T_WAITC;
         T_WAITC: state_in = (dim_n == 7'd0) ? T_WRC : T_RDAB;
         T_RDAB:  state_in = T_MAC;
         T_MAC:   state_in = T_WAITF;
         T_WAITF: if (fpu_rsp.valid) state_in = last_k ? T_WRC : T_RDAB;
         T_WRC:   state_in = (last_j && last_i) ? T_IDLE : T_RDC;
         default: state_in = T_CLEAR;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_ready     = (state_ff == T_IDLE) && (!rsp_valid_ff || rsp_ready);
      a_raddr       = mem_addr(i_ff, k_ff);
      b_raddr       = mem_addr(k_ff, j_ff);
      c_raddr       = (state_ff == T_IDLE) ? req_addr : mem_addr(i_ff, j_ff);
      a_we          = 1'b0;
      b_we          = 1'b0;
      c_we          = 1'b0;
      c_waddr       = req_addr;
      c_wdata       = req_element_bits;
      rsp_load      = 1'b0;
      rsp_status_in = 1'b0;
      rsp_bits_in   = 32'd0;
      unique case (state_ff)
         T_CLEAR: begin
            c_we    = 1'b1;
            c_waddr = clr_ff;
            c_wdata = 32'd0;
         end
         T_IDLE: begin
            if (req_fire) begin
               unique case (req_type)
                  REQ_LOAD_A: begin
                     a_we          = rng_a;
                     rsp_load      = 1'b1;
                     rsp_status_in = !rng_a;
                  end
                  REQ_LOAD_B: begin
                     b_we          = rng_b;
                     rsp_load      = 1'b1;
                     rsp_status_in = !rng_b;
                  end
                  REQ_LOAD_C: begin
                     c_we          = rng_c;
                     rsp_load      = 1'b1;
                     rsp_status_in = !rng_c;
                  end
                  REQ_COMPUTE: begin
                     // empty C: nothing to do, answer at once
                     rsp_load = (dim_m == 7'd0) || (dim_p == 7'd0);
                  end
                  REQ_READ_C: begin
                     rsp_load      = !rng_c;
                     rsp_status_in = 1'b1;
                  end
                  default: begin
                     rsp_load      = 1'b1;
                     rsp_status_in = 1'b1;
                  end
               endcase
            end
         end
         T_READ: begin
            rsp_load    = 1'b1;
            rsp_bits_in = c_rdata_ff;
         end
         T_WRC: begin
            c_we     = 1'b1;
            c_waddr  = mem_addr(i_ff, j_ff);
            c_wdata  = acc_ff;
            rsp_load = last_j && last_i;
         end
         default: ;
      endcase
   end

   assign fpu_req.valid    = (state_ff == T_MAC);
   assign fpu_req.a_bits   = a_rdata_ff;
   assign fpu_req.b_bits   = b_rdata_ff;
   assign fpu_req.acc_bits = acc_ff;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= T_CLEAR;
         rows_ff      <= DIM_RESET;
         inner_ff     <= DIM_RESET;
         cols_ff      <= DIM_RESET;
         clr_ff       <= '0;
         i_ff         <= 7'd0;
         j_ff         <= 7'd0;
         k_ff         <= 7'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_fire) begin
            case (csr_index)
               REG_ROWS_A:    rows_ff  <= csr_wdata;
               REG_INNER_DIM: inner_ff <= csr_wdata;
               REG_COLS_B:    cols_ff  <= csr_wdata;
               default: ;
            endcase
         end
         if (state_ff == T_CLEAR) clr_ff <= clr_ff + AW'(1);
         if (rsp_load) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
         if (state_ff == T_IDLE && req_fire) begin
            i_ff <= 7'd0;
            j_ff <= 7'd0;
         end
         if (state_ff == T_WAITC) k_ff <= 7'd0;
         if (state_ff == T_WAITF && fpu_rsp.valid) k_ff <= k_ff + 7'd1;
         if (state_ff == T_WRC) begin
            if (last_j) begin
               j_ff <= 7'd0;
               i_ff <= i_ff + 7'd1;
            end else begin
               j_ff <= j_ff + 7'd1;
            end
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_status_ff <= rsp_status_in;
         rsp_bits_ff   <= rsp_bits_in;
      end
      if (state_ff == T_WAITC) acc_ff <= c_rdata_ff;
      if (state_ff == T_WAITF && fpu_rsp.valid) acc_ff <= fpu_rsp.sum_bits;
   end

   // memories, registered read port
   always_ff @(posedge clock) begin
      if (a_we) a_mem[req_addr] <= req_element_bits;
      a_rdata_ff <= a_mem[a_raddr];
   end

   always_ff @(posedge clock) begin
      if (b_we) b_mem[req_addr] <= req_element_bits;
      b_rdata_ff <= b_mem[b_raddr];
   end

   always_ff @(posedge clock) begin
      if (c_we) c_mem[c_waddr] <= c_wdata;
      c_rdata_ff <= c_mem[c_raddr];
   end

endmodule

>>> sv/fmma_fpu.sv
// Multi-cycle binary32 multiply then add (separately rounded, round to nearest even).
// Depends on fmma_pkg; one shared normalize/round back end serves both operations.
module fmma_fpu (
   input  logic                  clock,
   input  logic                  reset,
   input  fmma_pkg::fpu_req_type fpu_req,
   output fmma_pkg::fpu_rsp_type fpu_rsp
);
   import fmma_pkg::*;

   fpu_state_type state_ff, state_in;
   logic          phase_ff;
   logic          done_ff;
   logic          take, finish;

   logic [31:0]        a_ff, b_ff, acc_ff, prod_ff, res_ff, spec_bits_ff;
   logic               spec_ff, sign_ff, zsign_ff, sub_ff;
   logic signed [9:0]  exp_ff;
   logic [50:0]        man_ff;
   logic [5:0]         lz_ff;
   logic [49:0]        x_ff, y_ff;

   // multiply step
   logic [47:0]        mul_man;
   logic signed [9:0]  mul_exp;
   logic               mul_spec;
   logic [31:0]        mul_spec_bits;
   // align step
   logic               al_swap;
   logic [31:0]        al_big, al_sml;
   logic [7:0]         al_d;
   logic [49:0]        al_wide, al_mask, al_y;
   logic               al_spec;
   logic [31:0]        al_spec_bits;
   // add step
   logic [50:0]        add_sum;
   // denormal step
   logic signed [9:0]  den_sh;
   logic [50:0]        den_mask, den_man;
   // round step
   logic               rnd_big, rnd_inc;
   logic [7:0]         rnd_efield;
   logic [30:0]        rnd_sum;
   logic [31:0]        rnd_bits;

   function automatic logic f_nan(input logic [31:0] v);
      return (v[30:23] == 8'hFF) && (v[22:0] != 23'd0);
   endfunction

   function automatic logic f_inf(input logic [31:0] v);
      return (v[30:23] == 8'hFF) && (v[22:0] == 23'd0);
   endfunction

   function automatic logic f_zero(input logic [31:0] v);
      return v[30:0] == 31'd0;
   endfunction

   function automatic logic [7:0] f_exp(input logic [31:0] v);
      return (v[30:23] == 8'd0) ? 8'd1 : v[30:23];
   endfunction

   function automatic logic [23:0] f_man(input logic [31:0] v);
      return {|v[30:23], v[22:0]};
   endfunction

   function automatic logic [5:0] f_lzc(input logic [50:0] v);
      logic [5:0] lz;
      lz = 6'd51;
      for (int b = 0; b < 51; b++) begin
         if (v[b]) lz = 6'(50 - b);
      end
      return lz;
   endfunction

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         F_IDLE:  if (fpu_req.valid) state_in = F_MUL;
         F_MUL:   state_in = F_LZC;
         F_LZC:   state_in = F_NORM;
         F_NORM:  state_in = F_DEN;
         F_DEN:   state_in = F_RND;
         F_RND:   state_in = phase_ff ? F_IDLE : F_ALIGN;
         F_ALIGN: state_in = F_ADD;
         F_ADD:   state_in = F_LZC;
         default: state_in = F_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      take   = (state_ff == F_IDLE) && fpu_req.valid;
      finish = (state_ff == F_RND) && phase_ff;
   end

   assign fpu_rsp.valid    = done_ff;
   assign fpu_rsp.sum_bits = res_ff;

   // product of the two significands, exponent of a value normalized at bit 50
   always_comb begin
      mul_man = 48'(f_man(a_ff)) * 48'(f_man(b_ff));
      mul_exp = $signed({2'b00, f_exp(a_ff)}) + $signed({2'b00, f_exp(b_ff)}) - 10'sd126;
      mul_spec      = 1'b0;
      mul_spec_bits = CANON_NAN;
      if (f_nan(a_ff) || f_nan(b_ff) || (f_inf(a_ff) && f_zero(b_ff)) ||
          (f_zero(a_ff) && f_inf(b_ff))) begin
         mul_spec = 1'b1;
      end else if (f_inf(a_ff) || f_inf(b_ff)) begin
         mul_spec      = 1'b1;
         mul_spec_bits = {a_ff[31] ^ b_ff[31], 8'hFF, 23'd0};
      end
   end

   // larger magnitude first; smaller one shifted right with a sticky bit
   always_comb begin
      al_swap = prod_ff[30:0] > acc_ff[30:0];
      al_big  = al_swap ? prod_ff : acc_ff;
      al_sml  = al_swap ? acc_ff : prod_ff;
      al_d    = f_exp(al_big) - f_exp(al_sml);
      al_wide = {f_man(al_sml), 26'd0};
      al_mask = (50'(1) << al_d[5:0]) - 50'(1);
      if (al_d >= 8'd50) begin
         al_y = {49'd0, |f_man(al_sml)};
      end else begin
         al_y = (al_wide >> al_d[5:0]) | {49'd0, |(al_wide & al_mask)};
      end
      al_spec      = 1'b0;
      al_spec_bits = CANON_NAN;
      if (f_nan(acc_ff) || f_nan(prod_ff) ||
          (f_inf(acc_ff) && f_inf(prod_ff) && (acc_ff[31] != prod_ff[31]))) begin
         al_spec = 1'b1;
      end else if (f_inf(acc_ff)) begin
         al_spec      = 1'b1;
         al_spec_bits = acc_ff;
      end else if (f_inf(prod_ff)) begin
         al_spec      = 1'b1;
         al_spec_bits = prod_ff;
      end
   end

   assign add_sum = sub_ff ? ({1'b0, x_ff} - {1'b0, y_ff}) : ({1'b0, x_ff} + {1'b0, y_ff});

   // gradual underflow: shift right so the exponent field becomes zero
   always_comb begin
      den_sh   = 10'sd1 - exp_ff;
      den_mask = (51'(1) << den_sh[5:0]) - 51'(1);
      if (den_sh >= 10'sd51) begin
         den_man = {50'd0, |man_ff};
      end else begin
         den_man = (man_ff >> den_sh[5:0]) | {50'd0, |(man_ff & den_mask)};
      end
   end

   // round to nearest even; a carry out of the fraction bumps the exponent field
   always_comb begin
      rnd_big    = exp_ff >= 10'sd255;
      rnd_efield = (exp_ff >= 10'sd1) ? exp_ff[7:0] : 8'd0;
      rnd_inc    = man_ff[26] & (man_ff[27] | (|man_ff[25:0]));
      rnd_sum    = {rnd_efield, man_ff[49:27]} + 31'(rnd_inc);
      if (spec_ff) begin
         rnd_bits = spec_bits_ff;
      end else if (man_ff == 51'd0) begin
         rnd_bits = {sign_ff, 31'd0};
      end else if (rnd_big) begin
         rnd_bits = {sign_ff, 8'hFF, 23'd0};
      end else begin
         rnd_bits = {sign_ff, rnd_sum};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         phase_ff <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= finish;
         if (take) phase_ff <= 1'b0;
         else if (state_ff == F_ALIGN) phase_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         a_ff   <= fpu_req.a_bits;
         b_ff   <= fpu_req.b_bits;
         acc_ff <= fpu_req.acc_bits;
      end
      case (state_ff)
         F_MUL: begin
            man_ff       <= {mul_man, 3'd0};
            exp_ff       <= mul_exp;
            sign_ff      <= a_ff[31] ^ b_ff[31];
            spec_ff      <= mul_spec;
            spec_bits_ff <= mul_spec_bits;
         end
         F_LZC: lz_ff <= f_lzc(man_ff);
         F_NORM: begin
            man_ff <= man_ff << lz_ff;
            exp_ff <= exp_ff - $signed({4'd0, lz_ff});
         end
         F_DEN: begin
            if (exp_ff <= 10'sd0) begin
               man_ff <= den_man;
               exp_ff <= 10'sd0;
            end
         end
         F_RND: begin
            if (phase_ff) res_ff <= rnd_bits;
            else prod_ff <= rnd_bits;
         end
         F_ALIGN: begin
            x_ff         <= {f_man(al_big), 26'd0};
            y_ff         <= al_y;
            sub_ff       <= al_big[31] ^ al_sml[31];
            sign_ff      <= al_big[31];
            zsign_ff     <= al_big[31] & al_sml[31];
            exp_ff       <= $signed({2'b00, f_exp(al_big)}) + 10'sd1;
            spec_ff      <= al_spec;
            spec_bits_ff <= al_spec_bits;
         end
         F_ADD: begin
            man_ff <= add_sum;
            if (add_sum == 51'd0) sign_ff <= zsign_ff;
         end
         default: ;
      endcase
   end

endmodule

>>> sv/fmma_checker.sv
// Port-level checks of the matrix multiply-accumulate unit, bound to its top level.
// Depends on fmma_pkg for the request type codes.
module fmma_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic [2:0]  req_type,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_status,
   input logic [31:0] rsp_read_bits
);
   import fmma_pkg::*;

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_read_bits))
      else $error("result changed while stalled");

   // an error never carries data
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status |-> rsp_read_bits == 32'd0)
      else $error("error result with nonzero data");

   // C is being cleared right after reset
   assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !req_ready)
      else $error("item taken during clearing pass");

   // an undefined request answers an error in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_type != REQ_LOAD_A && req_type != REQ_LOAD_B &&
      req_type != REQ_LOAD_C && req_type != REQ_COMPUTE && req_type != REQ_READ_C
      |=> rsp_valid && rsp_status)
      else $error("undefined request not rejected");

endmodule

bind float_matrix_multiply_accumulate_unit fmma_checker u_fmma_checker (.*);

>>> sim/float_matrix_multiply_accumulate_unit_tb.sv
// Testbench of the single-precision matrix multiply-accumulate unit (C := C + A*B).
// Depends on fmma_pkg and the RTL; holds its own bit-exact binary32 predictor of the block.
module float_matrix_multiply_accumulate_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import fmma_pkg::*;

   localparam int MAX_DIM     = 64;
   localparam int ITEM_TARGET = 1600;
   localparam int CYCLE_LIMIT = 3000000;
   localparam int HOLD_LEN    = 300;
   localparam int DRAIN_WAIT  = 20;

   typedef struct {
      logic        status;
      logic [31:0] bits;
   } rsp_item_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [2:0]  req_type = REQ_LOAD_A;
   logic [5:0]  req_row_index = '0;
   logic [5:0]  req_col_index = '0;
   logic [31:0] req_element_bits = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_status;
   logic [31:0] rsp_read_bits;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = REG_ROWS_A;
   logic [6:0]  csr_wdata = '0;

   // predictor state: operand and accumulator memories, written-flags for A and B
   logic [31:0] a_mem [MAX_DIM*MAX_DIM];
   logic [31:0] b_mem [MAX_DIM*MAX_DIM];
   logic [31:0] c_mem [MAX_DIM*MAX_DIM];
   bit          a_written [MAX_DIM*MAX_DIM];
   bit          b_written [MAX_DIM*MAX_DIM];
   logic [6:0]  rows_reg, inner_reg, cols_reg;

   rsp_item_type expected_q[$];
   int          fail_count = 0;
   int          items_sent = 0;
   int          cycle_count = 0;
   int          send_idle_pct = 0;
   int          recv_stall_pct = 0;
   bit          hold_on = 1'b0;
   int          held_cycles = 0;

   float_matrix_multiply_accumulate_unit #(.MAX_DIM(MAX_DIM)) u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_type(req_type),
      .req_row_index(req_row_index), .req_col_index(req_col_index),
      .req_element_bits(req_element_bits),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_status(rsp_status),
      .rsp_read_bits(rsp_read_bits),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------------------------------
   // binary32 arithmetic, round to nearest even, gradual underflow, NaN made canonical
   // ---------------------------------------------------------------------------------------

   // value = sig * 2^e2 exactly (sig nonzero); round it into a binary32 word
   function automatic logic [31:0] fp_round(logic s, int e2, logic [127:0] sig);
      int           msb, sh, be;
      logic [127:0] m, rem, half;
      msb = 127;
      while (!sig[msb]) msb--;
      sh = msb - 23;
      if (-149 - e2 > sh) sh = -149 - e2;   // subnormal: fix the scale at 2^-149
      if (sh > 120) begin
         m = '0;
      end else if (sh > 0) begin
         m    = sig >> sh;
         rem  = sig & ((128'd1 << sh) - 128'd1);
         half = 128'd1 << (sh - 1);
         if (rem > half || (rem == half && m[0])) m = m + 128'd1;
      end else begin
         m = sig << (-sh);
      end
      if (m[24]) begin          // rounding carried into a new bit
         m  = m >> 1;
         sh = sh + 1;
      end
      be = m[23] ? e2 + sh + 150 : 0;
      if (be >= 255) return {s, 8'hFF, 23'd0};
      return {s, be[7:0], m[22:0]};
   endfunction

   function automatic bit fp_is_nan(logic [31:0] x);
      return x[30:23] == 8'hFF && x[22:0] != 0;
   endfunction

   function automatic bit fp_is_inf(logic [31:0] x);
      return x[30:23] == 8'hFF && x[22:0] == 0;
   endfunction

   function automatic bit fp_is_zero(logic [31:0] x);
      return x[30:0] == 0;
   endfunction

   function automatic logic [127:0] fp_sig(logic [31:0] x);
      return (x[30:23] == 0) ? {105'd0, x[22:0]} : {104'd0, 1'b1, x[22:0]};
   endfunction

   function automatic int fp_exp(logic [31:0] x);
      return (x[30:23] == 0) ? -149 : int'(x[30:23]) - 150;
   endfunction

   function automatic logic [31:0] fp_mul(logic [31:0] x, logic [31:0] y);
      logic s;
      s = x[31] ^ y[31];
      if (fp_is_nan(x) || fp_is_nan(y)) return CANON_NAN;
      if (fp_is_inf(x) || fp_is_inf(y)) begin
         if (fp_is_zero(x) || fp_is_zero(y)) return CANON_NAN;
         return {s, 8'hFF, 23'd0};
      end
      if (fp_is_zero(x) || fp_is_zero(y)) return {s, 31'd0};
      return fp_round(s, fp_exp(x) + fp_exp(y), fp_sig(x) * fp_sig(y));
   endfunction

   function automatic logic [31:0] fp_add(logic [31:0] x, logic [31:0] y);
      logic [31:0]  lg, sm;
      logic [127:0] big, tiny, total;
      int           d, e;
      logic         s;
      if (fp_is_nan(x) || fp_is_nan(y)) return CANON_NAN;
      if (fp_is_inf(x) && fp_is_inf(y)) return (x[31] != y[31]) ? CANON_NAN : x;
      if (fp_is_inf(x)) return x;
      if (fp_is_inf(y)) return y;
      if (fp_is_zero(x) && fp_is_zero(y)) return {x[31] & y[31], 31'd0};
      if (fp_is_zero(x)) return y;
      if (fp_is_zero(y)) return x;
      if (fp_exp(x) >= fp_exp(y)) begin
         lg = x; sm = y;
      end else begin
         lg = y; sm = x;
      end
      d = fp_exp(lg) - fp_exp(sm);
      if (d > 60) begin
         // far below half an ulp: only its sign and being nonzero matter
         big  = fp_sig(lg) << 40;
         tiny = 128'd1;
         e    = fp_exp(lg) - 40;
      end else begin
         big  = fp_sig(lg) << d;
         tiny = fp_sig(sm);
         e    = fp_exp(sm);
      end
      if (lg[31] == sm[31]) begin
         total = big + tiny; s = lg[31];
      end else if (big >= tiny) begin
         total = big - tiny; s = lg[31];
      end else begin
         total = tiny - big; s = sm[31];
      end
      if (total == 0) return 32'd0;   // exact cancellation gives +0
      return fp_round(s, e, total);
   endfunction

   // ---------------------------------------------------------------------------------------
   // predictor of the block
   // ---------------------------------------------------------------------------------------
   function automatic int eff_dim(logic [6:0] v);
      return (int'(v) > MAX_DIM) ? MAX_DIM : int'(v);
   endfunction

   function automatic void run_gemm();
      int          m, n, p;
      logic [31:0] acc;
      m = eff_dim(rows_reg); n = eff_dim(inner_reg); p = eff_dim(cols_reg);
      for (int i = 0; i < m; i++)
         for (int j = 0; j < p; j++) begin
            acc = c_mem[i*MAX_DIM + j];
            for (int k = 0; k < n; k++)
               acc = fp_add(acc, fp_mul(a_mem[i*MAX_DIM + k], b_mem[k*MAX_DIM + j]));
            c_mem[i*MAX_DIM + j] = acc;
         end
   endfunction

   function automatic rsp_item_type predict_response(logic [2:0] t, logic [5:0] r,
                                                     logic [5:0] c, logic [31:0] w);
      rsp_item_type res;
      int        m, n, p, adr;
      m = eff_dim(rows_reg); n = eff_dim(inner_reg); p = eff_dim(cols_reg);
      adr = int'(r) * MAX_DIM + int'(c);
      res.status = 1'b1;
      res.bits   = '0;
      case (t)
         REQ_LOAD_A: begin
            if (r < m && c < n) begin
               a_mem[adr] = w; a_written[adr] = 1'b1; res.status = 1'b0;
            end
         end
         REQ_LOAD_B: begin
            if (r < n && c < p) begin
               b_mem[adr] = w; b_written[adr] = 1'b1; res.status = 1'b0;
            end
         end
         REQ_LOAD_C: begin
            if (r < m && c < p) begin
               c_mem[adr] = w; res.status = 1'b0;
            end
         end
         REQ_COMPUTE: begin
            run_gemm();
            res.status = 1'b0;
         end
         REQ_READ_C: begin
            if (r < m && c < p) begin
               res.bits = c_mem[adr]; res.status = 1'b0;
            end
         end
         default: ;
      endcase
      return res;
   endfunction

   // ---------------------------------------------------------------------------------------
   // drivers
   // ---------------------------------------------------------------------------------------

   // one item on the request channel; expectation is formed when it is accepted
   task automatic send_item(logic [2:0] t, logic [5:0] r, logic [5:0] c, logic [31:0] w);
      int gap;
      gap = 0;
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_type         <= t;
      req_row_index    <= r;
      req_col_index    <= c;
      req_element_bits <= w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected_q.push_back(predict_response(t, r, c, w));
      items_sent++;
   endtask

   // drop valid and let every outstanding result come back
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [6:0] val);
      wait_idle();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      case (idx)
         REG_ROWS_A:    rows_reg  = val;
         REG_INNER_DIM: inner_reg = val;
         REG_COLS_B:    cols_reg  = val;
         default: ;
      endcase
   endtask

   task automatic set_dims(logic [6:0] m, logic [6:0] n, logic [6:0] p);
      write_reg(REG_ROWS_A, m);
      write_reg(REG_INNER_DIM, n);
      write_reg(REG_COLS_B, p);
   endtask

   task automatic set_idle(int sender_pct, int receiver_pct);
      send_idle_pct  = sender_pct;
      recv_stall_pct = receiver_pct;
   endtask

   // mostly moderate magnitudes so sums interact, plus every special class
   function automatic logic [31:0] rand_float();
      logic [31:0] w;
      w = $urandom;
      case ($urandom_range(15))
         0: w = {w[31], 31'd0};
         1: w = {w[31], 8'hFF, 23'd0};
         2: w = {w[31], 8'hFF, w[22:1], 1'b1};
         3: w = {w[31], 8'h00, w[22:0]};
         4: w = {w[31], 8'($urandom_range(250, 254)), w[22:0]};
         5: w = {w[31], 8'($urandom_range(1, 10)), w[22:0]};
         6, 7: ;
         default: w = {w[31], 8'($urandom_range(118, 136)), w[22:0]};
      endcase
      return w;
   endfunction

   // a compute must never touch an operand that was never loaded
   task automatic fill_operands();
      int m, n, p;
      m = eff_dim(rows_reg); n = eff_dim(inner_reg); p = eff_dim(cols_reg);
      for (int i = 0; i < m; i++)
         for (int k = 0; k < n; k++)
            if (!a_written[i*MAX_DIM + k]) send_item(REQ_LOAD_A, 6'(i), 6'(k), rand_float());
      for (int k = 0; k < n; k++)
         for (int j = 0; j < p; j++)
            if (!b_written[k*MAX_DIM + j]) send_item(REQ_LOAD_B, 6'(k), 6'(j), rand_float());
   endtask

   // ---------------------------------------------------------------------------------------
   // result checker and ready generation
   // ---------------------------------------------------------------------------------------

   // length of the long receiver hold-off, in cycles
   always @(posedge clock) begin
      if (!reset && hold_on && held_cycles < HOLD_LEN) held_cycles <= held_cycles + 1;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_q.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("ERROR: unexpected result status=%0b bits=%08h",
                           rsp_status, rsp_read_bits);
            end else begin
               rsp_item_type exp_item;
               exp_item = expected_q.pop_front();
               if (rsp_status !== exp_item.status || rsp_read_bits !== exp_item.bits) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("ERROR: result mismatch status exp %0b got %0b, bits exp %08h got %08h",
                              exp_item.status, rsp_status, exp_item.bits, rsp_read_bits);
               end
            end
         end
         // long hold-off once requested, otherwise random stalls per phase
         if (hold_on && held_cycles < HOLD_LEN) begin
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------------------------

   // C comes up cleared; reads at the default 64x64 size, corners included
   task automatic test_reset_state();
      send_item(REQ_READ_C, 6'd0, 6'd0, 32'hFFFF_FFFF);
      send_item(REQ_READ_C, 6'd63, 6'd63, 32'd0);
      send_item(REQ_READ_C, 6'd21, 6'd42, $urandom);
   endtask

   // range checks on every load and read, undefined codes, compute ignoring its fields
   task automatic test_bounds_and_types();
      set_dims(7'd2, 7'd3, 7'd2);
      fill_operands();
      send_item(REQ_LOAD_A, 6'd1, 6'd2, rand_float());
      send_item(REQ_LOAD_A, 6'd2, 6'd0, rand_float());
      send_item(REQ_LOAD_A, 6'd0, 6'd3, rand_float());
      send_item(REQ_LOAD_B, 6'd2, 6'd1, rand_float());
      send_item(REQ_LOAD_B, 6'd3, 6'd0, rand_float());
      send_item(REQ_LOAD_B, 6'd0, 6'd2, rand_float());
      send_item(REQ_LOAD_C, 6'd1, 6'd1, rand_float());
      send_item(REQ_LOAD_C, 6'd2, 6'd1, rand_float());
      send_item(REQ_READ_C, 6'd1, 6'd2, 32'd0);
      send_item(REQ_READ_C, 6'd63, 6'd63, 32'd0);
      for (int t = int'(REQ_READ_C) + 1; t < 8; t++)
         send_item(3'(t), 6'($urandom), 6'($urandom), $urandom);
      send_item(REQ_COMPUTE, 6'h3F, 6'h3F, 32'hFFFF_FFFF);
      for (int i = 0; i < 2; i++)
         for (int j = 0; j < 2; j++) send_item(REQ_READ_C, 6'(i), 6'(j), 32'd0);
   endtask

   // infinities, NaN, signed zeros and underflow through the multiply-add chain
   task automatic test_special_values();
      logic [31:0] a_set [3][4] = '{
         '{32'h7F80_0000, 32'h3F80_0000, 32'h0000_0001, 32'h8000_0000},
         '{32'h7F7F_FFFF, 32'h7F7F_FFFF, 32'h0080_0000, 32'h3F00_0000},
         '{32'hFF80_0000, 32'h7F80_0001, 32'h8000_0000, 32'h0000_0000}};
      logic [31:0] b_set [3][4] = '{
         '{32'h3F80_0000, 32'h8000_0000, 32'h0000_0001, 32'h0000_0000},
         '{32'hBF80_0000, 32'h3F80_0000, 32'h0040_0000, 32'h0000_0003},
         '{32'h3F80_0000, 32'h3F80_0000, 32'h8000_0000, 32'h8000_0000}};
      set_dims(7'd1, 7'd4, 7'd1);
      // a NaN loaded into C reads back untouched until a compute
      send_item(REQ_LOAD_C, 6'd0, 6'd0, 32'h7F80_0001);
      send_item(REQ_READ_C, 6'd0, 6'd0, 32'd0);
      for (int s = 0; s < 3; s++) begin
         for (int k = 0; k < 4; k++) begin
            send_item(REQ_LOAD_A, 6'd0, 6'(k), a_set[s][k]);
            send_item(REQ_LOAD_B, 6'(k), 6'd0, b_set[s][k]);
         end
         if (s > 0) send_item(REQ_LOAD_C, 6'd0, 6'd0, (s == 1) ? 32'h8000_0000 : 32'h0);
         send_item(REQ_COMPUTE, 6'd0, 6'd0, 32'd0);
         send_item(REQ_READ_C, 6'd0, 6'd0, 32'd0);
      end
   endtask

   // empty dimensions and sizes above MAX_DIM (saturated)
   task automatic test_size_extremes();
      set_dims(7'd0, 7'd2, 7'd2);
      send_item(REQ_LOAD_A, 6'd0, 6'd0, rand_float());
      send_item(REQ_READ_C, 6'd0, 6'd0, 32'd0);
      send_item(REQ_COMPUTE, 6'd0, 6'd0, 32'd0);
      set_dims(7'd1, 7'd0, 7'd1);
      send_item(REQ_LOAD_B, 6'd0, 6'd0, rand_float());
      send_item(REQ_LOAD_C, 6'd0, 6'd0, 32'h4049_0FDB);
      send_item(REQ_COMPUTE, 6'd0, 6'd0, 32'd0);
      send_item(REQ_READ_C, 6'd0, 6'd0, 32'd0);
      set_dims(7'd1, 7'd1, 7'd0);
      send_item(REQ_READ_C, 6'd0, 6'd0, 32'd0);
      send_item(REQ_COMPUTE, 6'd0, 6'd0, 32'd0);
      set_dims(7'd127, 7'd1, 7'd1);
      fill_operands();
      send_item(REQ_LOAD_A, 6'd63, 6'd0, rand_float());
      send_item(REQ_COMPUTE, 6'd0, 6'd0, 32'd0);
      send_item(REQ_READ_C, 6'd63, 6'd0, 32'd0);
      set_dims(7'd1, 7'd64, 7'd1);
      fill_operands();
      send_item(REQ_COMPUTE, 6'd0, 6'd0, 32'd0);
      send_item(REQ_READ_C, 6'd0, 6'd0, 32'd0);
      set_dims(7'd1, 7'd1, 7'd100);
      fill_operands();
      send_item(REQ_LOAD_C, 6'd0, 6'd63, rand_float());
      send_item(REQ_COMPUTE, 6'd0, 6'd0, 32'd0);
      send_item(REQ_READ_C, 6'd0, 6'd63, 32'd0);
   endtask

   // receiver holds off for a long stretch while items keep coming
   task automatic test_backpressure();
      set_dims(7'd4, 7'd4, 7'd4);
      fill_operands();
      set_idle(0, 0);
      hold_on = 1'b1;
      for (int i = 0; i < 60; i++) begin
         if (i % 2 == 0)
            send_item(REQ_LOAD_C, 6'($urandom_range(3)), 6'($urandom_range(3)), rand_float());
         else
            send_item(REQ_READ_C, 6'($urandom_range(3)), 6'($urandom_range(3)), 32'd0);
      end
      send_item(REQ_COMPUTE, 6'd0, 6'd0, 32'd0);
      send_item(REQ_READ_C, 6'd3, 6'd3, 32'd0);
   endtask

   // random rounds: new sizes, operands made complete, then a mix of all requests
   task automatic test_random();
      int          round_no, sel, n_ops, m, n, p, op;
      logic [5:0]  r, c;
      logic [6:0]  dm, dn, dp;
      round_no = 0;
      while (items_sent < ITEM_TARGET) begin
         case ((round_no / 3) % 4)
            0: set_idle(0, 0);
            1: set_idle(70, 0);
            2: set_idle(0, 70);
            default: set_idle(29, 29);
         endcase
         sel = $urandom_range(19);
         dm = 7'($urandom_range(1, 4));
         dn = 7'($urandom_range(1, 4));
         dp = 7'($urandom_range(1, 4));
         if (sel == 0) begin
            case ($urandom_range(2))
               0: dm = '0;
               1: dn = '0;
               default: dp = '0;
            endcase
         end else if (sel == 1) begin
            dm = 7'd1; dn = 7'd1; dp = 7'd1;
            case ($urandom_range(2))
               0: dm = 7'($urandom_range(64, 127));
               1: dn = 7'($urandom_range(64, 127));
               default: dp = 7'($urandom_range(64, 127));
            endcase
         end else if (sel < 5) begin
            dm = 7'($urandom_range(1, 8));
            dn = 7'($urandom_range(1, 8));
            dp = 7'($urandom_range(1, 6));
         end
         set_dims(dm, dn, dp);
         fill_operands();
         m = eff_dim(dm); n = eff_dim(dn); p = eff_dim(dp);
         n_ops = $urandom_range(20, 40);
         for (int i = 0; i < n_ops; i++) begin
            op = $urandom_range(99);
            r  = 6'($urandom);
            c  = 6'($urandom);
            // mostly in range, the rest anywhere in the index space
            if ($urandom_range(4) != 0) begin
               if (op < 30) begin
                  if (m > 0) r = 6'($urandom_range(m - 1));
                  if (n > 0) c = 6'($urandom_range(n - 1));
               end else if (op < 45) begin
                  if (n > 0) r = 6'($urandom_range(n - 1));
                  if (p > 0) c = 6'($urandom_range(p - 1));
               end else begin
                  if (m > 0) r = 6'($urandom_range(m - 1));
                  if (p > 0) c = 6'($urandom_range(p - 1));
               end
            end
            if (op < 30)       send_item(REQ_LOAD_A, r, c, rand_float());
            else if (op < 45)  send_item(REQ_LOAD_B, r, c, rand_float());
            else if (op < 60)  send_item(REQ_LOAD_C, r, c, rand_float());
            else if (op < 65)  send_item(REQ_COMPUTE, r, c, $urandom);
            else if (op < 97)  send_item(REQ_READ_C, r, c, $urandom);
            else               send_item(3'($urandom_range(int'(REQ_READ_C) + 1, 7)), r, c,
                                         $urandom);
         end
         send_item(REQ_COMPUTE, 6'($urandom), 6'($urandom), $urandom);
         for (int i = 0; i < 4; i++)
            send_item(REQ_READ_C, 6'($urandom_range(p > 0 ? p : 1)),
                      6'($urandom_range(p > 0 ? p - 1 : 0)), 32'd0);
         round_no++;
      end
      set_idle(0, 0);
   endtask

   initial begin
      rows_reg  = DIM_RESET;
      inner_reg = DIM_RESET;
      cols_reg  = DIM_RESET;
      for (int i = 0; i < MAX_DIM*MAX_DIM; i++) begin
         a_mem[i] = '0; b_mem[i] = '0; c_mem[i] = '0;
      end
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_state();
      test_bounds_and_types();
      test_special_values();
      test_size_extremes();
      test_backpressure();
      test_random();
      req_valid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (fail_count == 0 && expected_q.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
